FILE: src/vpm_pkg.sv
// Package for the planar VGA port and memory block: sizes, port and index codes,
// the port register set and the port write decode shared with the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vpm_pkg;

  // Sizes (both must be powers of two, offsets and indices wrap by masking)
  localparam int WINDOW_WORDS = 65536;
  localparam int PALETTE_SIZE = 256;
  localparam int WIN_AW       = $clog2(WINDOW_WORDS);
  localparam int PAL_AW       = $clog2(PALETTE_SIZE);
  localparam int NUM_PLANES   = 4;
  localparam int NUM_COMPS    = 3;

  // Bus operations
  typedef enum logic [2:0] {
    OP_IO_READ    = 3'd0,
    OP_IO_WRITE_B = 3'd1,
    OP_IO_WRITE_W = 3'd2,
    OP_MEM_READ   = 3'd3,
    OP_MEM_WRITE  = 3'd4,
    OP_PAL_LOOKUP = 3'd5
  } op_t;

  // I/O ports
  localparam logic [15:0] PORT_SEQ_INDEX  = 16'h03C4;
  localparam logic [15:0] PORT_SEQ_DATA   = 16'h03C5;
  localparam logic [15:0] PORT_DAC_WINDEX = 16'h03C8;
  localparam logic [15:0] PORT_DAC_DATA   = 16'h03C9;
  localparam logic [15:0] PORT_GC_INDEX   = 16'h03CE;
  localparam logic [15:0] PORT_GC_DATA    = 16'h03CF;
  localparam logic [15:0] PORT_CRTC_INDEX = 16'h03D4;
  localparam logic [15:0] PORT_CRTC_DATA  = 16'h03D5;

  // Register indices
  localparam logic [4:0] SEQ_MAP_MASK   = 5'h02;
  localparam logic [4:0] CRTC_SPAN      = 5'h01;
  localparam logic [4:0] CRTC_START_HI  = 5'h0C;
  localparam logic [4:0] CRTC_START_LO  = 5'h0D;
  localparam logic [4:0] CRTC_LINES     = 5'h13;
  localparam logic [2:0] GC_MODE        = 3'd5;

  // DAC component codes
  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;
  localparam logic [1:0] COMP_SKIP  = 2'd3;

  // Write modes (graphics controller mode register bits 1:0)
  localparam logic [1:0] WMODE_PLANES = 2'd0;
  localparam logic [1:0] WMODE_LATCH  = 2'd1;

  // Reset values of the display registers
  localparam logic [10:0] LINES_RESET = 11'd320;
  localparam logic [10:0] SPAN_RESET  = 11'd200;

  // Port-side register set
  typedef struct packed {
    logic [4:0]      shared_index;
    logic [3:0]      plane_mask;
    logic [9:0]      dac_pointer;
    logic [2:0]      gc_select;
    logic [7:0][7:0] gc_bank;
    logic [15:0]     start;
    logic [10:0]     lines;
    logic [10:0]     span;
  } port_regs_t;

  // Reset value of the port-side register set
  localparam port_regs_t REGS_RESET = '{
    shared_index: '0, plane_mask: '0, dac_pointer: '0, gc_select: '0,
    gc_bank: '0, start: '0, lines: LINES_RESET, span: SPAN_RESET
  };

  // One palette component write
  typedef struct packed {
    logic              we;
    logic [1:0]        comp;
    logic [PAL_AW-1:0] col;
    logic [7:0]        data;
  } dac_wr_t;

  typedef struct packed {
    port_regs_t regs;
    dac_wr_t    dac;
  } port_upd_t;

  // Apply one byte write to a port
  function automatic port_upd_t port_write(port_upd_t cur, logic [15:0] port,
                                           logic [7:0] v);
    port_upd_t  nx;
    logic [1:0] comp;
    nx   = cur;
    comp = cur.regs.dac_pointer[1:0];
    unique case (port)
      PORT_SEQ_INDEX:  nx.regs.shared_index = {3'b000, v[1:0]};
      PORT_SEQ_DATA: begin
        if (cur.regs.shared_index == SEQ_MAP_MASK) nx.regs.plane_mask = v[3:0];
      end
      PORT_DAC_WINDEX: nx.regs.dac_pointer = {v, 2'b00};
      PORT_DAC_DATA: begin
        // component three stores nothing, only steps the pointer
        if (comp != COMP_SKIP) begin
          nx.dac.we   = 1'b1;
          nx.dac.comp = comp;
          nx.dac.col  = cur.regs.dac_pointer[PAL_AW+1:2];
          nx.dac.data = {v[5:0], 2'b00};
        end
        nx.regs.dac_pointer = cur.regs.dac_pointer +
                              ((comp == COMP_BLUE) ? 10'd2 : 10'd1);
      end
      PORT_GC_INDEX:   nx.regs.gc_select = v[2:0];
      PORT_GC_DATA:    nx.regs.gc_bank[cur.regs.gc_select] = v;
      PORT_CRTC_INDEX: nx.regs.shared_index = v[4:0];
      PORT_CRTC_DATA: begin
        unique case (cur.regs.shared_index)
          CRTC_SPAN:     nx.regs.span = {({1'b0, v} + 9'd1), 2'b00};
          CRTC_START_HI: nx.regs.start[15:8] = v;
          CRTC_START_LO: nx.regs.start[7:0] = v;
          CRTC_LINES:    nx.regs.lines = {v, 3'b000};
          default: ;
        endcase
      end
      default: ;
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

FILE: src/vga_planar_port_and_memory.sv
// Top level of the planar VGA port and memory block.
// Depends on vpm_pkg and vpm_ram.
//
// One bus word is taken in every cycle in which start is high and busy is low,
// and its result appears behind the input register and the registered read of
// the plane and palette RAMs (or the result stage registers), with out_valid high
// for one cycle; the result cannot be held off, so it must be taken when shown.
// After reset busy stays high while the plane memory (WINDOW_WORDS, 65536 words)
// and the palette are swept to zero, one word per cycle; after that busy stays
// low.
`timescale 1ns / 1ps
`default_nettype none

module vga_planar_port_and_memory (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_location,
  input  wire logic [15:0] in_wdata,
  output logic             out_valid,
  output logic [7:0]       out_read_byte,
  output logic [23:0]      out_palette_color,
  output logic [15:0]      out_display_start,
  output logic [10:0]      out_display_lines,
  output logic [10:0]      out_display_span
);

  localparam int AW = vpm_pkg::WIN_AW;
  localparam int PW = vpm_pkg::PAL_AW;

  // Clearing sweep
  logic [AW:0] clr_cnt_r;
  logic        accept;

  assign busy   = ~clr_cnt_r[AW];
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Input register
  logic        s1_valid_r;
  logic [2:0]  s1_op_r;
  logic [15:0] s1_loc_r;
  logic [15:0] s1_wdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_op;
      s1_loc_r   <= in_location;
      s1_wdata_r <= in_wdata;
    end
  end

  // Port registers and port decode
  vpm_pkg::port_regs_t regs_r, regs_nxt;
  vpm_pkg::port_upd_t  upd;
  logic [7:0]          io_byte;

  always_comb begin
    upd.regs = regs_r;
    upd.dac  = '0;
    io_byte  = '0;
    if (s1_valid_r) begin
      unique case (vpm_pkg::op_t'(s1_op_r))
        vpm_pkg::OP_IO_READ: begin
          if (s1_loc_r == vpm_pkg::PORT_GC_DATA) io_byte = regs_r.gc_bank[regs_r.gc_select];
        end
        vpm_pkg::OP_IO_WRITE_B: upd = vpm_pkg::port_write(upd, s1_loc_r, s1_wdata_r[7:0]);
        vpm_pkg::OP_IO_WRITE_W: begin
          // high byte follows to the next port, wrapping at the top
          upd = vpm_pkg::port_write(upd, s1_loc_r, s1_wdata_r[7:0]);
          upd = vpm_pkg::port_write(upd, s1_loc_r + 16'd1, s1_wdata_r[15:8]);
        end
        default: ;
      endcase
    end
    regs_nxt = upd.regs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= vpm_pkg::REGS_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Result stage registers
  logic        s2_valid_r;
  logic [2:0]  s2_op_r;
  logic [3:0]  s2_mask_r;
  logic [7:0]  s2_io_byte_r;
  logic [15:0] s2_start_r;
  logic [10:0] s2_lines_r;
  logic [10:0] s2_span_r;
  logic        s2_mem_read;

  assign s2_mem_read = s2_valid_r && (s2_op_r == vpm_pkg::OP_MEM_READ);

  // Plane memory, one RAM per plane
  logic [31:0]         plane_rdata;
  logic [31:0]         latches_r;
  logic [31:0]         latches_cur;
  logic [3:0]          plane_we;
  logic [3:0][7:0]     plane_wdata;
  logic [AW-1:0]       plane_addr;
  logic                mem_write;
  logic [1:0]          wmode;

  // a read one word ahead reloads the latches from the RAM output
  assign latches_cur = s2_mem_read ? plane_rdata : latches_r;
  assign mem_write   = s1_valid_r && (s1_op_r == vpm_pkg::OP_MEM_WRITE);
  assign wmode       = regs_r.gc_bank[vpm_pkg::GC_MODE][1:0];
  assign plane_addr  = busy ? clr_cnt_r[AW-1:0] : s1_loc_r[AW-1:0];

  always_comb begin
    for (int i = 0; i < vpm_pkg::NUM_PLANES; i++) begin
      if (busy) begin
        plane_we[i]    = 1'b1;
        plane_wdata[i] = '0;
      end else if (wmode == vpm_pkg::WMODE_LATCH) begin
        plane_we[i]    = mem_write;
        plane_wdata[i] = latches_cur[8*i +: 8];
      end else begin
        plane_we[i]    = mem_write && (wmode == vpm_pkg::WMODE_PLANES) && regs_r.plane_mask[i];
        plane_wdata[i] = s1_wdata_r[7:0];
      end
    end
  end

  for (genvar g = 0; g < vpm_pkg::NUM_PLANES; g++) begin : g_plane
    vpm_ram #(
      .WIDTH (8),
      .DEPTH (vpm_pkg::WINDOW_WORDS)
    ) u_plane (
      .clk   (clk),
      .we    (plane_we[g]),
      .addr  (plane_addr),
      .wdata (plane_wdata[g]),
      .rdata (plane_rdata[8*g +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latches_r <= '0;
    end else if (s2_mem_read) begin
      latches_r <= plane_rdata;
    end
  end

  // Palette, one RAM per colour component, cleared by the same sweep
  logic [2:0]      pal_we;
  logic [2:0]      pal_ram_we;
  logic [PW-1:0]   pal_addr;
  logic [7:0]      pal_wdata;
  logic [2:0][7:0] pal_rdata;

  assign pal_addr  = busy ? clr_cnt_r[PW-1:0] :
                     (upd.dac.we ? upd.dac.col : s1_loc_r[PW-1:0]);
  assign pal_wdata = busy ? 8'd0 : upd.dac.data;

  always_comb begin
    for (int c = 0; c < vpm_pkg::NUM_COMPS; c++) begin
      pal_we[c]     = upd.dac.we && (upd.dac.comp == 2'(c));
      pal_ram_we[c] = busy | pal_we[c];
    end
  end

  for (genvar g = 0; g < vpm_pkg::NUM_COMPS; g++) begin : g_comp
    vpm_ram #(
      .WIDTH (8),
      .DEPTH (vpm_pkg::PALETTE_SIZE)
    ) u_pal (
      .clk   (clk),
      .we    (pal_ram_we[g]),
      .addr  (pal_addr),
      .wdata (pal_wdata),
      .rdata (pal_rdata[g])
    );
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r      <= s1_op_r;
    s2_mask_r    <= regs_r.plane_mask;
    s2_io_byte_r <= io_byte;
    s2_start_r   <= regs_nxt.start;
    s2_lines_r   <= regs_nxt.lines;
    s2_span_r    <= regs_nxt.span;
  end

  // Output word
  logic [7:0] plane_byte;

  always_comb begin
    priority if (s2_mask_r[0]) plane_byte = plane_rdata[7:0];
    else if (s2_mask_r[1])     plane_byte = plane_rdata[15:8];
    else if (s2_mask_r[2])     plane_byte = plane_rdata[23:16];
    else if (s2_mask_r[3])     plane_byte = plane_rdata[31:24];
    else                       plane_byte = '0;
  end

  always_comb begin
    out_read_byte     = '0;
    out_palette_color = '0;
    unique case (vpm_pkg::op_t'(s2_op_r))
      vpm_pkg::OP_IO_READ:  out_read_byte = s2_io_byte_r;
      vpm_pkg::OP_MEM_READ: out_read_byte = plane_byte;
      vpm_pkg::OP_PAL_LOOKUP: begin
        out_palette_color = {pal_rdata[vpm_pkg::COMP_RED],
                             pal_rdata[vpm_pkg::COMP_GREEN],
                             pal_rdata[vpm_pkg::COMP_BLUE]};
      end
      default: ;
    endcase
  end

  assign out_valid         = s2_valid_r;
  assign out_display_start = s2_start_r;
  assign out_display_lines = s2_lines_r;
  assign out_display_span  = s2_span_r;

  // Checks
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !busy)
    else $error("busy rose again after the clearing sweep");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("accepted word gave no result two cycles later");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without an accepted word");

  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !busy)
    else $error("bus access overlaps the clearing sweep");

  a_one_component: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(pal_we))
    else $error("more than one palette component written at once");

endmodule

`default_nettype wire

FILE: src/vpm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: verif/vga_planar_port_and_memory_checker.sv
// Scoreboard for the planar VGA port and memory block: keeps its own copy of the
// port registers, palette, latches and plane memory, and checks every result word.
// Depends on vpm_pkg for the sizes, reset values and the op, port, index, component and write mode codes.
`timescale 1ns / 1ps

module vga_planar_port_and_memory_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_location,
  input  wire logic [15:0] in_wdata,
  input  wire logic        out_valid,
  input  wire logic [7:0]  out_read_byte,
  input  wire logic [23:0] out_palette_color,
  input  wire logic [15:0] out_display_start,
  input  wire logic [10:0] out_display_lines,
  input  wire logic [10:0] out_display_span,
  output int               fail_count,
  output int               pending
);

  import vpm_pkg::*;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [23:0] colour;
    logic [15:0] start_addr;
    logic [10:0] lines;
    logic [10:0] span;
  } bus_reply_t;

  // Mirror of the adapter state
  logic [4:0]  seq_crtc_index;
  logic [3:0]  map_mask;
  logic [9:0]  dac_ptr;
  logic [23:0] palette [PALETTE_SIZE];
  logic [2:0]  gc_index;
  logic [7:0]  gc_regs [8];
  logic [15:0] disp_start;
  logic [10:0] disp_lines;
  logic [10:0] disp_span;
  logic [31:0] read_latch;
  logic [31:0] vram [WINDOW_WORDS];

  bus_reply_t awaited_replies [$];
  bus_reply_t want;

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("%0t: %s mismatch: got %0h, want %0h", $time, field, got, exp_val);
    fail_count++;
  endtask

  // One byte written to an I/O port
  function automatic void port_byte_write(logic [15:0] port, logic [7:0] v);
    logic [1:0] comp;
    logic [7:0] dac_byte;
    int         col;
    comp     = dac_ptr[1:0];
    col      = int'(dac_ptr[9:2]) % PALETTE_SIZE;
    dac_byte = {v[5:0], 2'b00};
    case (port)
      PORT_SEQ_INDEX:  seq_crtc_index = {3'b000, v[1:0]};
      PORT_SEQ_DATA: begin
        if (seq_crtc_index == SEQ_MAP_MASK) map_mask = v[3:0];
      end
      PORT_DAC_WINDEX: dac_ptr = {v, 2'b00};
      PORT_DAC_DATA: begin
        case (comp)
          COMP_RED:   palette[col][23:16] = dac_byte;
          COMP_GREEN: palette[col][15:8]  = dac_byte;
          COMP_BLUE:  palette[col][7:0]   = dac_byte;
          default: ;
        endcase
        // blue steps past the unused fourth slot
        dac_ptr = dac_ptr + ((comp == COMP_BLUE) ? 10'd2 : 10'd1);
      end
      PORT_GC_INDEX:   gc_index = v[2:0];
      PORT_GC_DATA:    gc_regs[gc_index] = v;
      PORT_CRTC_INDEX: seq_crtc_index = v[4:0];
      PORT_CRTC_DATA: begin
        case (seq_crtc_index)
          CRTC_SPAN:     disp_span = 11'((11'(v) + 11'd1) << 2);
          CRTC_START_HI: disp_start[15:8] = v;
          CRTC_START_LO: disp_start[7:0] = v;
          CRTC_LINES:    disp_lines = 11'(11'(v) << 3);
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Apply one bus word to the mirror and work out its result word
  function automatic bus_reply_t predict_reply(logic [2:0] op, logic [15:0] loc,
                                               logic [15:0] wd);
    bus_reply_t  r;
    logic [31:0] w;
    int          a;
    int          p;
    r = '0;
    a = int'(loc) % WINDOW_WORDS;
    case (op)
      OP_IO_READ: begin
        if (loc == PORT_GC_DATA) r.read_byte = gc_regs[gc_index];
      end
      OP_IO_WRITE_B: port_byte_write(loc, wd[7:0]);
      OP_IO_WRITE_W: begin
        port_byte_write(loc, wd[7:0]);
        port_byte_write(loc + 16'd1, wd[15:8]);
      end
      OP_MEM_READ: begin
        w          = vram[a];
        read_latch = w;
        // lowest masked plane wins
        for (p = NUM_PLANES - 1; p >= 0; p--)
          if (map_mask[p]) r.read_byte = w[8*p +: 8];
      end
      OP_MEM_WRITE: begin
        case (gc_regs[GC_MODE][1:0])
          WMODE_PLANES: begin
            w = vram[a];
            for (p = 0; p < NUM_PLANES; p++)
              if (map_mask[p]) w[8*p +: 8] = wd[7:0];
            vram[a] = w;
          end
          WMODE_LATCH: vram[a] = read_latch;
          default: ;
        endcase
      end
      OP_PAL_LOOKUP: r.colour = palette[int'(loc) % PALETTE_SIZE];
      default: ;
    endcase
    r.start_addr = disp_start;
    r.lines      = disp_lines;
    r.span       = disp_span;
    return r;
  endfunction

  // Compare result words first, then take in the word accepted at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_crtc_index = '0;
      map_mask       = '0;
      dac_ptr        = '0;
      gc_index       = '0;
      disp_start     = '0;
      disp_lines     = LINES_RESET;
      disp_span      = SPAN_RESET;
      read_latch     = '0;
      foreach (palette[i]) palette[i] = '0;
      foreach (gc_regs[i]) gc_regs[i] = '0;
      foreach (vram[i]) vram[i] = '0;
      awaited_replies.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (awaited_replies.size() == 0) begin
          note_mismatch("unawaited word", 32'(out_read_byte), 32'd0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_read_byte !== want.read_byte)
            note_mismatch("read_byte", 32'(out_read_byte), 32'(want.read_byte));
          if (out_palette_color !== want.colour)
            note_mismatch("palette_color", 32'(out_palette_color), 32'(want.colour));
          if (out_display_start !== want.start_addr)
            note_mismatch("display_start", 32'(out_display_start),
                          32'(want.start_addr));
          if (out_display_lines !== want.lines)
            note_mismatch("display_lines", 32'(out_display_lines), 32'(want.lines));
          if (out_display_span !== want.span)
            note_mismatch("display_span", 32'(out_display_span), 32'(want.span));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        awaited_replies.push_back(predict_reply(in_op, in_location, in_wdata));
    end
    pending <= awaited_replies.size();
  end

endmodule

FILE: verif/vga_planar_port_and_memory_tb.sv
// Testbench top for the planar VGA port and memory block: clock, reset, stimulus
// and verdict. Depends on vpm_pkg, the block itself and its scoreboard module.
`timescale 1ns / 1ps

module vga_planar_port_and_memory_tb;

  import vpm_pkg::*;

  localparam logic [2:0]  OP_RESERVED_6  = 3'd6;
  localparam logic [2:0]  OP_RESERVED_7  = 3'd7;
  localparam logic [15:0] PORT_KEYBOARD  = 16'h0060;
  localparam logic [15:0] PORT_TOP       = 16'hFFFF;
  localparam int          RANDOM_WORDS   = 1500;
  localparam int          DRAIN_CYCLES   = 200;
  localparam int          TIMEOUT_NS     = 5_000_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_op;
  logic [15:0] in_location;
  logic [15:0] in_wdata;
  logic        out_valid;
  logic [7:0]  out_read_byte;
  logic [23:0] out_palette_color;
  logic [15:0] out_display_start;
  logic [10:0] out_display_lines;
  logic [10:0] out_display_span;
  int          fail_count;
  int          pending;

  int idle_pct;
  int words_sent;

  always #5 clk = ~clk;

  vga_planar_port_and_memory u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_location       (in_location),
    .in_wdata          (in_wdata),
    .out_valid         (out_valid),
    .out_read_byte     (out_read_byte),
    .out_palette_color (out_palette_color),
    .out_display_start (out_display_start),
    .out_display_lines (out_display_lines),
    .out_display_span  (out_display_span)
  );

  vga_planar_port_and_memory_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_location       (in_location),
    .in_wdata          (in_wdata),
    .out_valid         (out_valid),
    .out_read_byte     (out_read_byte),
    .out_palette_color (out_palette_color),
    .out_display_start (out_display_start),
    .out_display_lines (out_display_lines),
    .out_display_span  (out_display_span),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Offer one word after a random gap; return once it has been taken
  task automatic send_word(input logic [2:0] op, input logic [15:0] loc,
                           input logic [15:0] wd);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_location <= loc;
    in_wdata    <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  // Small pool of window offsets at both ends, so reads find earlier writes
  function automatic logic [15:0] near_offset();
    logic [15:0] a;
    a = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) a = a | 16'hFFF8;
    return a;
  endfunction

  // Plane mask, maybe a write mode, then a run of window accesses
  task automatic planar_burst();
    logic [1:0] mode;
    mode = ($urandom_range(0, 3) == 0) ? 2'($urandom) : WMODE_PLANES;
    send_word(OP_IO_WRITE_W, PORT_SEQ_INDEX, {8'($urandom), 3'b000, SEQ_MAP_MASK});
    if ($urandom_range(0, 1))
      send_word(OP_IO_WRITE_W, PORT_GC_INDEX, {6'($urandom), mode, 5'b0, GC_MODE});
    repeat ($urandom_range(2, 6))
      send_word($urandom_range(0, 1) ? OP_MEM_WRITE : OP_MEM_READ, near_offset(),
                16'($urandom));
  endtask

  // Latch copy from one offset to another
  task automatic latch_copy();
    logic [15:0] dst;
    dst = near_offset();
    send_word(OP_MEM_READ, near_offset(), 16'($urandom));
    send_word(OP_IO_WRITE_W, PORT_GC_INDEX, {6'($urandom), WMODE_LATCH, 5'b0, GC_MODE});
    send_word(OP_MEM_WRITE, dst, 16'($urandom));
    send_word(OP_IO_WRITE_B, PORT_GC_DATA, {8'($urandom), 6'($urandom), WMODE_PLANES});
    send_word(OP_MEM_READ, dst, 16'($urandom));
  endtask

  // Load some palette components and look the colour up
  task automatic dac_load();
    logic [7:0] col;
    col = 8'($urandom);
    if ($urandom_range(0, 3) == 0)
      send_word(OP_IO_WRITE_W, PORT_DAC_WINDEX, {8'($urandom), col});
    else
      send_word(OP_IO_WRITE_B, PORT_DAC_WINDEX, {8'($urandom), col});
    repeat ($urandom_range(1, 6)) send_word(OP_IO_WRITE_B, PORT_DAC_DATA, 16'($urandom));
    send_word(OP_PAL_LOOKUP, {8'($urandom), col}, 16'($urandom));
    send_word(OP_PAL_LOOKUP, 16'($urandom), 16'($urandom));
  endtask

  // CRTC register write, as a word or as index and data bytes
  task automatic crtc_write();
    logic [4:0] idx;
    case ($urandom_range(0, 4))
      0:       idx = CRTC_SPAN;
      1:       idx = CRTC_START_HI;
      2:       idx = CRTC_START_LO;
      3:       idx = CRTC_LINES;
      default: idx = 5'($urandom);
    endcase
    if ($urandom_range(0, 1)) begin
      send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'($urandom), 3'($urandom), idx});
    end else begin
      send_word(OP_IO_WRITE_B, PORT_CRTC_INDEX, {8'($urandom), 3'($urandom), idx});
      send_word(OP_IO_WRITE_B, PORT_CRTC_DATA, 16'($urandom));
    end
  endtask

  // Graphics controller index select, with a register write if sent as a word, and read-back
  task automatic gc_access();
    send_word($urandom_range(0, 1) ? OP_IO_WRITE_W : OP_IO_WRITE_B, PORT_GC_INDEX,
              16'($urandom));
    send_word(OP_IO_READ, PORT_GC_DATA, 16'($urandom));
  endtask

  // Anything at all, with ports often near the adapter range
  task automatic noise_word();
    logic [15:0] loc;
    loc = $urandom_range(0, 1) ? 16'($urandom) : (16'h03C0 | 16'($urandom_range(0, 31)));
    send_word(3'($urandom), loc, 16'($urandom));
  endtask

  // Timeout
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int random_base;
    int guard;
    int pick;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= OP_IO_READ;
    in_location <= '0;
    in_wdata    <= '0;
    idle_pct    = 22;
    words_sent  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, keyboard port, empty-mask read
    send_word(OP_IO_READ, PORT_GC_DATA, 16'h0000);
    send_word(OP_IO_READ, PORT_KEYBOARD, 16'hFFFF);
    send_word(OP_MEM_READ, 16'hFFFF, 16'h0000);
    // all planes, write and read back at the top of the window
    send_word(OP_IO_WRITE_W, PORT_SEQ_INDEX, {8'h0F, 3'b000, SEQ_MAP_MASK});
    send_word(OP_MEM_WRITE, 16'hFFFF, 16'h00FF);
    send_word(OP_MEM_READ, 16'hFFFF, 16'h0000);
    // latch copy, then write modes two and three leave memory alone
    send_word(OP_IO_WRITE_W, PORT_GC_INDEX, {6'b0, WMODE_LATCH, 5'b0, GC_MODE});
    send_word(OP_MEM_WRITE, 16'h0000, 16'h0000);
    send_word(OP_IO_WRITE_B, PORT_GC_DATA, 16'h0002);
    send_word(OP_MEM_WRITE, 16'h0000, 16'hFF55);
    send_word(OP_IO_WRITE_B, PORT_GC_DATA, 16'hFF03);
    send_word(OP_MEM_WRITE, 16'h0001, 16'h00AA);
    send_word(OP_IO_READ, PORT_GC_DATA, 16'h0000);
    send_word(OP_IO_WRITE_B, PORT_GC_DATA, {8'h00, 6'b0, WMODE_PLANES});
    send_word(OP_MEM_READ, 16'h0000, 16'h0000);
    // sequencer data at an unused index leaves the mask alone
    send_word(OP_IO_WRITE_W, PORT_SEQ_INDEX, 16'h0100);
    send_word(OP_MEM_READ, 16'h0001, 16'h0000);
    // last colour, all three components and a wrap of the pointer
    send_word(OP_IO_WRITE_B, PORT_DAC_WINDEX, 16'h00FF);
    repeat (4) send_word(OP_IO_WRITE_B, PORT_DAC_DATA, 16'h00FF);
    send_word(OP_PAL_LOOKUP, 16'hFFFF, 16'h0000);
    send_word(OP_PAL_LOOKUP, 16'h0000, 16'h0000);
    // CRTC extremes and an unused index
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'hFF, 3'b000, CRTC_SPAN});
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'h00, 3'b000, CRTC_SPAN});
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'hFF, 3'b000, CRTC_START_HI});
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'h00, 3'b000, CRTC_START_LO});
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'hFF, 3'b000, CRTC_LINES});
    send_word(OP_IO_WRITE_W, PORT_CRTC_INDEX, {8'hFF, 8'h1F});
    // word write at the last port wraps to port zero; reserved ops
    send_word(OP_IO_WRITE_W, PORT_TOP, 16'hFFFF);
    send_word(OP_RESERVED_6, 16'hFFFF, 16'hFFFF);
    send_word(OP_RESERVED_7, 16'hFFFF, 16'hFFFF);

    // random part: sender idling light, then heavy, then none
    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      if (words_sent - random_base < RANDOM_WORDS / 3)
        idle_pct = 22;
      else if (words_sent - random_base < 2 * RANDOM_WORDS / 3)
        idle_pct = 57;
      else
        idle_pct = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30)      planar_burst();
      else if (pick < 40) latch_copy();
      else if (pick < 60) dac_load();
      else if (pick < 75) crtc_write();
      else if (pick < 85) gc_access();
      else                noise_word();
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < DRAIN_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/vpm_pkg.sv
src/vpm_ram.sv
src/vga_planar_port_and_memory.sv
verif/vga_planar_port_and_memory_checker.sv
verif/vga_planar_port_and_memory_tb.sv
